[hdl/dbfm_pkg.sv]
// Shared types and constants of the DPSK Barker-7 frame modulator.
`default_nettype none

package dbfm_pkg;

    localparam int FRAME_LEN    = 25;
    localparam int PAYLOAD_W    = 18;
    localparam int BARKER_W     = 7;
    localparam int SAMPLE_W     = 16;
    localparam int BIT_POS_W    = 5;

    localparam logic [BARKER_W-1:0]  BARKER_CODE  = 7'h72;
    localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = 5'(FRAME_LEN - 1);

    // Fixed-point constants of the sine table (Q30).
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_NUM     = 64'd131068;
    localparam logic [63:0] AMP_DEN     = 64'd5;
    localparam logic [63:0] MIDSCALE    = 64'd32767;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef struct packed {
        logic                 valid;
        func_t                func;
        logic [PAYLOAD_W-1:0] payload;
    } step_t;

    typedef struct packed {
        logic valid;
        logic phase_pi;
        logic frame_end;
    } res_t;

endpackage

`default_nettype wire

[hdl/dpsk_barker_frame_modulator.sv]
// Top level of the DPSK frame modulator with Barker-7 preamble.
`default_nettype none

// A beat with tuser = 0 loads an 18-bit payload and starts a 25-bit frame
// (Barker-7 code above the payload, sent MSB first); a beat with tuser = 1
// asks for the next DAC sample and yields one output beat while a frame is
// running, none when idle. Samples follow a sine of SINE_PERIOD samples,
// negated for the pi phase; each frame bit lasts SAMPLES_PER_BIT samples.
// The block takes one beat per cycle unless a held output beat stalls it;
// a beat passes through an input register, the frame counters plus a constant
// sine table lookup, and a result register.
module dpsk_barker_frame_modulator #(
    parameter int SAMPLES_PER_BIT = 20,
    parameter int SINE_PERIOD     = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // payload[17:0], zero fill
    input  wire logic [0:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // sample[15:0]
    output logic      [0:0]  m_axis_tuser,   // phase_pi
    output logic             m_axis_tlast    // frame_end
);
    import dbfm_pkg::*;

    localparam int KW = $clog2(SINE_PERIOD);

    logic                 in_valid_reg, in_valid_next;
    func_t                in_func_reg, in_func_next;
    logic [PAYLOAD_W-1:0] in_payload_reg, in_payload_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_sample_reg, out_sample_next;
    logic                 out_phase_reg, out_phase_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free;
    logic                 advance;
    step_t                step;
    res_t                 res;
    logic [KW-1:0]        k;
    logic [SAMPLE_W-1:0]  sample;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    assign step.valid   = advance;
    assign step.func    = in_func_reg;
    assign step.payload = in_payload_reg;

    dbfm_frame_seq #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .SINE_PERIOD     (SINE_PERIOD),
        .KW              (KW)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .res   (res),
        .k     (k)
    );

    dbfm_sine_rom #(
        .SINE_PERIOD (SINE_PERIOD),
        .KW          (KW)
    ) u_rom (
        .k        (k),
        .phase_pi (res.phase_pi),
        .sample   (sample)
    );

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_func_next    = in_func_reg;
        in_payload_next = in_payload_reg;
        if (s_axis_tready)
        begin
            in_valid_next   = s_axis_tvalid;
            in_func_next    = func_t'(s_axis_tuser[0]);
            in_payload_next = s_axis_tdata[PAYLOAD_W-1:0];
        end

        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_phase_next  = out_phase_reg;
        out_last_next   = out_last_reg;
        if (out_free)
        begin
            out_valid_next = res.valid;
            if (res.valid)
            begin
                out_sample_next = sample;
                out_phase_next  = res.phase_pi;
                out_last_next   = res.frame_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_func_reg    <= in_func_next;
        in_payload_reg <= in_payload_next;
        out_sample_reg <= out_sample_next;
        out_phase_reg  <= out_phase_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_sample_reg;
    assign m_axis_tuser[0] = out_phase_reg;
    assign m_axis_tlast    = out_last_reg;

    // The input side only stalls behind a held output beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_axis_tready) |-> (out_valid_reg && !m_axis_tready))
        else $error("input stalled while the result register was free");

    // A new output beat always comes from an item that left the input register.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("output beat appeared without an advancing item");

    // Only a tick produces a result.
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (advance && (in_func_reg == FUNC_TICK)))
        else $error("result produced by a load or without an item");

endmodule

`default_nettype wire

[hdl/dbfm_sine_rom.sv]
// Constant sine table: one DAC code per sample index for each carrier phase.
`default_nettype none

module dbfm_sine_rom #(
    parameter int SINE_PERIOD = 10,
    parameter int KW          = $clog2(SINE_PERIOD)
) (
    input  wire logic [KW-1:0]                k,
    input  wire logic                         phase_pi,
    output logic      [dbfm_pkg::SAMPLE_W-1:0] sample
);
    import dbfm_pkg::*;

    logic [SAMPLE_W-1:0] rom_zero [SINE_PERIOD];
    logic [SAMPLE_W-1:0] rom_pi   [SINE_PERIOD];

    // Each entry is worked out at elaboration: fold into the first quadrant,
    // Taylor series through y^17, then scale and offset to the DAC range.
    for (genvar g = 0; g < SINE_PERIOD; g++) begin : g_rom
        localparam logic [63:0] PER  = 64'(SINE_PERIOD);
        localparam logic [63:0] A    = 64'(4 * g);
        localparam logic [63:0] Q    = (A / PER) & 64'd3;
        localparam logic [63:0] R    = A % PER;
        localparam logic [63:0] NUM  = Q[0] ? (PER - R) : R;
        localparam logic        NEG  = Q[1];
        localparam logic [63:0] Y    = (HALF_PI_Q30 * NUM) / PER;
        localparam logic [63:0] Y2   = (Y * Y) >> 30;
        localparam logic [63:0] T1   = ((Y * Y2) >> 30) / 64'd6;
        localparam logic [63:0] S1   = (Y >= T1) ? Y - T1 : 64'd0;
        localparam logic [63:0] T2   = ((T1 * Y2) >> 30) / 64'd20;
        localparam logic [63:0] S2   = S1 + T2;
        localparam logic [63:0] T3   = ((T2 * Y2) >> 30) / 64'd42;
        localparam logic [63:0] S3   = (S2 >= T3) ? S2 - T3 : 64'd0;
        localparam logic [63:0] T4   = ((T3 * Y2) >> 30) / 64'd72;
        localparam logic [63:0] S4   = S3 + T4;
        localparam logic [63:0] T5   = ((T4 * Y2) >> 30) / 64'd110;
        localparam logic [63:0] S5   = (S4 >= T5) ? S4 - T5 : 64'd0;
        localparam logic [63:0] T6   = ((T5 * Y2) >> 30) / 64'd156;
        localparam logic [63:0] S6   = S5 + T6;
        localparam logic [63:0] T7   = ((T6 * Y2) >> 30) / 64'd210;
        localparam logic [63:0] S7   = (S6 >= T7) ? S6 - T7 : 64'd0;
        localparam logic [63:0] T8   = ((T7 * Y2) >> 30) / 64'd272;
        localparam logic [63:0] MAG  = S7 + T8;
        localparam logic [63:0] SCL  = AMP_NUM * MAG;
        localparam logic [63:0] BASE = MIDSCALE * AMP_DEN * ONE_Q30;
        localparam logic [63:0] DIV  = AMP_DEN * ONE_Q30;
        localparam logic [63:0] P0   = NEG ? (BASE - SCL) : (BASE + SCL);
        localparam logic [63:0] P1   = NEG ? (BASE + SCL) : (BASE - SCL);
        localparam logic [63:0] D0   = P0 / DIV;
        localparam logic [63:0] D1   = P1 / DIV;

        assign rom_zero[g] = D0[SAMPLE_W-1:0];
        assign rom_pi[g]   = D1[SAMPLE_W-1:0];
    end

    assign sample = phase_pi ? rom_pi[k] : rom_zero[k];

endmodule

`default_nettype wire

[hdl/dbfm_frame_seq.sv]
// Frame sequencer: frame shift register, carrier phase and bit/sample counters.
`default_nettype none

module dbfm_frame_seq #(
    parameter int SAMPLES_PER_BIT = 20,
    parameter int SINE_PERIOD     = 10,
    parameter int KW              = $clog2(SINE_PERIOD)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dbfm_pkg::step_t step,
    output dbfm_pkg::res_t       res,
    output logic      [KW-1:0]   k
);
    import dbfm_pkg::*;

    localparam int SPW = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 1;
    localparam logic [SPW-1:0] LAST_SAMPLE = SPW'(SAMPLES_PER_BIT - 1);
    localparam logic [KW-1:0]  LAST_K      = KW'(SINE_PERIOD - 1);

    logic [FRAME_LEN-1:0] frame_reg, frame_next;
    logic                 phase_reg, phase_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [SPW-1:0]       spos_reg, spos_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 sending_reg, sending_next;
    logic                 phase_cur;
    logic                 bit_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            phase_reg   <= 1'b0;
            bit_pos_reg <= '0;
            spos_reg    <= '0;
            k_reg       <= '0;
            sending_reg <= 1'b0;
        end
        else
        begin
            frame_reg   <= frame_next;
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            spos_reg    <= spos_next;
            k_reg       <= k_next;
            sending_reg <= sending_next;
        end
    end

    // The phase flips on the first sample of a bit whose frame bit is one.
    assign phase_cur = (spos_reg == '0) ? (phase_reg ^ frame_reg[FRAME_LEN-1]) : phase_reg;
    assign bit_end   = (spos_reg == LAST_SAMPLE);

    always_comb
    begin
        frame_next    = frame_reg;
        phase_next    = phase_reg;
        bit_pos_next  = bit_pos_reg;
        spos_next     = spos_reg;
        k_next        = k_reg;
        sending_next  = sending_reg;
        res.valid     = 1'b0;
        res.phase_pi  = phase_cur;
        res.frame_end = (bit_pos_reg == LAST_BIT_POS) && bit_end;
        k             = k_reg;

        if (step.valid)
        begin
            case (step.func)
                FUNC_LOAD:
                begin
                    frame_next   = {BARKER_CODE, step.payload};
                    phase_next   = step.payload[0];
                    bit_pos_next = '0;
                    spos_next    = '0;
                    k_next       = '0;
                    sending_next = 1'b1;
                end
                FUNC_TICK:
                begin
                    if (sending_reg)
                    begin
                        res.valid  = 1'b1;
                        phase_next = phase_cur;
                        if (bit_end)
                        begin
                            spos_next  = '0;
                            k_next     = '0;
                            frame_next = {frame_reg[FRAME_LEN-2:0], 1'b0};
                            if (bit_pos_reg == LAST_BIT_POS)
                            begin
                                bit_pos_next = '0;
                                sending_next = 1'b0;
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            spos_next = spos_reg + 1'b1;
                            k_next    = (k_reg == LAST_K) ? '0 : k_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
